// File: rtl/core/triangular_quantile_macros.svh
// ----------------------------------------------------------------------------
// triangular quantile assertion macros
// shared concurrent assertion forms for the quantile block
// ----------------------------------------------------------------------------
`ifndef TRIANGULAR_QUANTILE_MACROS_SVH
`define TRIANGULAR_QUANTILE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define TQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg
// types and constants of the triangular quantile block
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int unsigned VALUE_WIDTH_DEF     = 32;
  localparam int unsigned SQRT_ITERATIONS_DEF = 32;

  // exp unit
  localparam int unsigned EXP_TERMS   = 12;
  localparam int unsigned NDIV_BITS   = 5;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [31:0] LN2_Q32     = 32'hB17217F8;

  localparam logic signed [33:0] ONE_Q24   = 34'sd16777216;
  // log-probabilities at or below -18.0 give zero
  localparam logic signed [31:0] EXP_LIMIT = -32'sd301989888;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_PROB   = 2'd2
  } status_e;

  typedef enum logic {
    CFG_PROB_IS_LOG   = 1'b0,
    CFG_TAIL_IS_LOWER = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] prob;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] pk;
    logic               is_log;
    logic               lower;
  } item_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    status_e            status;
    logic               rising;
  } mid_t;

endpackage

// File: rtl/core/triangular_quantile.sv
// path from input accept to out_valid_o: input register, exp divider, taylor chain, scale, select, split, sqrt, output
// throughput: one item per cycle with an empty skid; the exp divider, taylor chain and square root are all pipelined
// a two-entry output (register plus skid) keeps the input open while a result waits
// reset clears all valid bits and sets prob_is_log = 0, tail_is_lower = 1
// ----------------------------------------------------------------------------
// triangular_quantile
// inverse cdf of a triangular distribution, signed q8.24 probability in,
// signed q16.16 quantile out, with optional log-probability and upper tail
// ----------------------------------------------------------------------------
`include "triangular_quantile_macros.svh"

module triangular_quantile #(
  parameter int unsigned VALUE_WIDTH     = tq_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned SQRT_ITERATIONS = tq_pkg::SQRT_ITERATIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic               cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] prob_in_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic signed [31:0] range_peak_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] quantile_o,
  output logic [1:0]         status_o
);

  localparam int unsigned SQ_N = (SQRT_ITERATIONS > 32) ? 32 : SQRT_ITERATIONS;
  localparam int unsigned ND   = tq_pkg::NDIV_BITS;
  localparam int unsigned NT   = tq_pkg::EXP_TERMS;

  localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

  // global advance: the whole pipe moves unless the skid entry is occupied
  logic adv;
  logic skid_valid_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic prob_is_log_q, tail_is_lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_is_log_q   <= 1'b0;
      tail_is_lower_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (tq_pkg::cfg_idx_e'(cfg_index_i))
        tq_pkg::CFG_PROB_IS_LOG:   prob_is_log_q   <= cfg_data_i;
        tq_pkg::CFG_TAIL_IS_LOWER: tail_is_lower_q <= cfg_data_i;
        default:                   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register, config bits travel with the item
  // --------------------------------------------------------------------------
  logic          in_valid_q;
  tq_pkg::item_t in_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_item_q.prob   <= prob_in_i;
      in_item_q.lo     <= range_low_i;
      in_item_q.hi     <= range_high_i;
      in_item_q.pk     <= range_peak_i;
      in_item_q.is_log <= prob_is_log_q;
      in_item_q.lower  <= tail_is_lower_q;
    end
  end

  // --------------------------------------------------------------------------
  // exp range reduction: t<<8 = n*ln2 + r, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [32:0] t_mag;
  assign t_mag = 33'd0 - {in_item_q.prob[31], in_item_q.prob};

  logic          dv_v_in    [ND];
  tq_pkg::item_t dv_item_in [ND];
  logic [36:0]   dv_rem_in  [ND];
  logic [ND-1:0] dv_n_in    [ND];
  logic [36:0]   dv_rem_d   [ND];
  logic [ND-1:0] dv_n_d     [ND];
  logic          dv_valid_q [ND];
  tq_pkg::item_t dv_item_q  [ND];
  logic [36:0]   dv_rem_q   [ND];
  logic [ND-1:0] dv_n_q     [ND];

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int unsigned B = ND - 1 - j;
    localparam logic [36:0] STEP = 37'(tq_pkg::LN2_Q32) << B;
    if (j == 0) begin : g_first
      assign dv_v_in[j]    = in_valid_q;
      assign dv_item_in[j] = in_item_q;
      assign dv_rem_in[j]  = {t_mag[28:0], 8'd0};
      assign dv_n_in[j]    = '0;
    end else begin : g_next
      assign dv_v_in[j]    = dv_valid_q[j-1];
      assign dv_item_in[j] = dv_item_q[j-1];
      assign dv_rem_in[j]  = dv_rem_q[j-1];
      assign dv_n_in[j]    = dv_n_q[j-1];
    end
    assign dv_rem_d[j] = (dv_rem_in[j] >= STEP) ? dv_rem_in[j] - STEP : dv_rem_in[j];
    assign dv_n_d[j]   = (dv_rem_in[j] >= STEP) ? (dv_n_in[j] | (ND'(1) << B)) : dv_n_in[j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ND; j++) dv_valid_q[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < ND; j++) dv_valid_q[j] <= dv_v_in[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < ND; j++) begin
        dv_item_q[j] <= dv_item_in[j];
        dv_rem_q[j]  <= dv_rem_d[j];
        dv_n_q[j]    <= dv_n_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // exp(-r) taylor chain: per term a multiply by r, then a reciprocal divide by k
  // --------------------------------------------------------------------------
  logic                ta_v_in    [NT];
  tq_pkg::item_t       ta_item_in [NT];
  logic [ND-1:0]       ta_n_in    [NT];
  logic [31:0]         ta_r_in    [NT];
  logic [32:0]         ta_term_in [NT];
  logic signed [34:0]  ta_sum_in  [NT];
  logic [64:0]         ta_prod    [NT];
  logic                ta_valid_q [NT];
  tq_pkg::item_t       ta_item_q  [NT];
  logic [ND-1:0]       ta_n_q     [NT];
  logic [31:0]         ta_r_q     [NT];
  logic [31:0]         ta_p_q     [NT];
  logic signed [34:0]  ta_sum_q   [NT];
  logic [32:0]         tb_term_d  [NT];
  logic                tb_valid_q [NT];
  tq_pkg::item_t       tb_item_q  [NT];
  logic [ND-1:0]       tb_n_q     [NT];
  logic [31:0]         tb_r_q     [NT];
  logic [32:0]         tb_term_q  [NT];
  logic signed [34:0]  tb_sum_q   [NT];

  for (genvar i = 0; i < NT; i++) begin : g_taylor
    localparam int unsigned K = i + 1;
    if (i == 0) begin : g_first
      assign ta_v_in[i]    = dv_valid_q[ND-1];
      assign ta_item_in[i] = dv_item_q[ND-1];
      assign ta_n_in[i]    = dv_n_q[ND-1];
      assign ta_r_in[i]    = dv_rem_q[ND-1][31:0];
      assign ta_term_in[i] = 33'h1_0000_0000;
      assign ta_sum_in[i]  = 35'sd4294967296;
    end else begin : g_next
      assign ta_v_in[i]    = tb_valid_q[i-1];
      assign ta_item_in[i] = tb_item_q[i-1];
      assign ta_n_in[i]    = tb_n_q[i-1];
      assign ta_r_in[i]    = tb_r_q[i-1];
      assign ta_term_in[i] = tb_term_q[i-1];
      // term i enters the sum here, odd terms subtract
      if ((i % 2) == 1) begin : g_sub
        assign ta_sum_in[i] = tb_sum_q[i-1] - $signed({2'b00, tb_term_q[i-1]});
      end else begin : g_add
        assign ta_sum_in[i] = tb_sum_q[i-1] + $signed({2'b00, tb_term_q[i-1]});
      end
    end
    assign ta_prod[i] = 65'(ta_term_in[i]) * 65'(ta_r_in[i]);

    if (K == 1) begin : g_div1
      assign tb_term_d[i] = {1'b0, ta_p_q[i]};
    end else begin : g_divk
      // exact floor division by k for 32-bit operands
      localparam logic [63:0] MF =
        ((64'd1 << tq_pkg::RECIP_SHIFT) + 64'(K) - 64'd1) / 64'(K);
      logic [67:0] qp;
      assign qp           = 68'(ta_p_q[i]) * 68'(MF[35:0]);
      assign tb_term_d[i] = {1'b0, qp[67:36]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        ta_valid_q[i] <= 1'b0;
        tb_valid_q[i] <= 1'b0;
      end
    end else if (adv) begin
      for (int i = 0; i < NT; i++) begin
        ta_valid_q[i] <= ta_v_in[i];
        tb_valid_q[i] <= ta_valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NT; i++) begin
        ta_item_q[i] <= ta_item_in[i];
        ta_n_q[i]    <= ta_n_in[i];
        ta_r_q[i]    <= ta_r_in[i];
        ta_p_q[i]    <= ta_prod[i][63:32];
        ta_sum_q[i]  <= ta_sum_in[i];
        tb_item_q[i] <= ta_item_q[i];
        tb_n_q[i]    <= ta_n_q[i];
        tb_r_q[i]    <= ta_r_q[i];
        tb_term_q[i] <= tb_term_d[i];
        tb_sum_q[i]  <= ta_sum_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // last term, clamp, then round and scale by 2^-n down to q.24
  // --------------------------------------------------------------------------
  logic signed [34:0] f1_sum_d;
  logic               f1_valid_q;
  tq_pkg::item_t      f1_item_q;
  logic [ND-1:0]      f1_n_q;
  logic [33:0]        f1_sum_q;
  logic [34:0]        f2_rnd;
  logic [34:0]        f2_shift;
  logic               f2_valid_q;
  tq_pkg::item_t      f2_item_q;
  logic [24:0]        f2_exp_q;

  if ((NT % 2) == 1) begin : g_last_sub
    assign f1_sum_d = tb_sum_q[NT-1] - $signed({2'b00, tb_term_q[NT-1]});
  end else begin : g_last_add
    assign f1_sum_d = tb_sum_q[NT-1] + $signed({2'b00, tb_term_q[NT-1]});
  end

  assign f2_rnd   = {1'b0, f1_sum_q} + (35'd1 << (6'(f1_n_q) + 6'd7));
  assign f2_shift = f2_rnd >> (6'(f1_n_q) + 6'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= tb_valid_q[NT-1];
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_item_q <= tb_item_q[NT-1];
      f1_n_q    <= tb_n_q[NT-1];
      f1_sum_q  <= f1_sum_d[34] ? 34'd0 : f1_sum_d[33:0];
      f2_item_q <= f1_item_q;
      f2_exp_q  <= f2_shift[24:0];
    end
  end

  // --------------------------------------------------------------------------
  // probability select, tail flip, status and widths
  // --------------------------------------------------------------------------
  logic signed [33:0] g_q_sel, g_q_tail;
  logic [32:0]        g_w_full, g_d_full, g_e_full;
  tq_pkg::mid_t       g_mid_d;
  logic               g_valid_q;
  logic [24:0]        g_q_q;
  logic [31:0]        g_w_q, g_d_q, g_e_q;
  tq_pkg::mid_t       g_mid_q;

  always_comb begin
    priority if (!f2_item_q.is_log) begin
      g_q_sel = 34'(f2_item_q.prob);
    end else if (f2_item_q.prob > 32'sd0) begin
      // exp of a positive value lies above one
      g_q_sel = tq_pkg::ONE_Q24 + 34'sd1;
    end else if (f2_item_q.prob <= tq_pkg::EXP_LIMIT) begin
      g_q_sel = '0;
    end else begin
      g_q_sel = $signed({9'd0, f2_exp_q});
    end
    g_q_tail = f2_item_q.lower ? g_q_sel : tq_pkg::ONE_Q24 - g_q_sel;

    g_mid_d.lo     = f2_item_q.lo;
    g_mid_d.hi     = f2_item_q.hi;
    g_mid_d.rising = 1'b0;
    priority if (f2_item_q.lo >= f2_item_q.hi || f2_item_q.pk > f2_item_q.hi ||
                 f2_item_q.lo > f2_item_q.pk) begin
      g_mid_d.status = tq_pkg::ST_BOUNDS;
    end else if (g_q_tail < 34'sd0 || g_q_tail > tq_pkg::ONE_Q24) begin
      g_mid_d.status = tq_pkg::ST_PROB;
    end else begin
      g_mid_d.status = tq_pkg::ST_OK;
    end
  end

  assign g_w_full = {f2_item_q.hi[31], f2_item_q.hi} - {f2_item_q.lo[31], f2_item_q.lo};
  assign g_d_full = {f2_item_q.pk[31], f2_item_q.pk} - {f2_item_q.lo[31], f2_item_q.lo};
  assign g_e_full = {f2_item_q.hi[31], f2_item_q.hi} - {f2_item_q.pk[31], f2_item_q.pk};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (adv) begin
      g_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_q_q   <= g_q_tail[24:0];
      g_w_q   <= g_w_full[31:0];
      g_d_q   <= g_d_full[31:0];
      g_e_q   <= g_e_full[31:0];
      g_mid_q <= g_mid_d;
    end
  end

  // --------------------------------------------------------------------------
  // branch split and radicand: q*w, compare, operand select, split product
  // --------------------------------------------------------------------------
  logic [56:0]  m1_prod;
  logic         m1_valid_q;
  logic [55:0]  m1_qw_q;
  logic [31:0]  m1_w_q, m1_d_q, m1_e_q;
  tq_pkg::mid_t m1_mid_q;
  logic         m2_rising;
  logic         m2_valid_q;
  logic [55:0]  m2_a_q;
  logic [31:0]  m2_f_q;
  tq_pkg::mid_t m2_mid_q;
  logic         m3_valid_q;
  logic [59:0]  m3_pl_q, m3_ph_q;
  tq_pkg::mid_t m3_mid_q;
  logic [87:0]  m4_sum;
  logic         m4_valid_q;
  logic [63:0]  m4_x_q;
  tq_pkg::mid_t m4_mid_q;

  assign m1_prod   = 57'(g_q_q) * 57'(g_w_q);
  assign m2_rising = m1_qw_q < {m1_d_q, 24'd0};
  // partial products recombined, radicand is floor(a*f / 2^24)
  assign m4_sum    = {m3_ph_q, 28'd0} + 88'(m3_pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      m3_valid_q <= 1'b0;
      m4_valid_q <= 1'b0;
    end else if (adv) begin
      m1_valid_q <= g_valid_q;
      m2_valid_q <= m1_valid_q;
      m3_valid_q <= m2_valid_q;
      m4_valid_q <= m3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_qw_q  <= m1_prod[55:0];
      m1_w_q   <= g_w_q;
      m1_d_q   <= g_d_q;
      m1_e_q   <= g_e_q;
      m1_mid_q <= g_mid_q;
      // falling branch uses (one-q)*w = w<<24 - q*w
      m2_a_q   <= m2_rising ? m1_qw_q : {m1_w_q, 24'd0} - m1_qw_q;
      m2_f_q   <= m2_rising ? m1_d_q : m1_e_q;
      m2_mid_q <= '{lo: m1_mid_q.lo, hi: m1_mid_q.hi, status: m1_mid_q.status,
                    rising: m2_rising};
      m3_pl_q  <= 60'(m2_a_q[27:0]) * 60'(m2_f_q);
      m3_ph_q  <= 60'(m2_a_q[55:28]) * 60'(m2_f_q);
      m3_mid_q <= m2_mid_q;
      m4_x_q   <= m4_sum[87:24];
      m4_mid_q <= m3_mid_q;
    end
  end

  // --------------------------------------------------------------------------
  // restoring square root, one result bit per stage, msb first
  // --------------------------------------------------------------------------
  logic         sq_v_in    [SQ_N];
  logic [63:0]  sq_rem_in  [SQ_N];
  logic [31:0]  sq_res_in  [SQ_N];
  tq_pkg::mid_t sq_mid_in  [SQ_N];
  logic [65:0]  sq_trial   [SQ_N];
  logic         sq_take    [SQ_N];
  logic         sq_valid_q [SQ_N];
  logic [63:0]  sq_rem_q   [SQ_N];
  logic [31:0]  sq_res_q   [SQ_N];
  tq_pkg::mid_t sq_mid_q   [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam int unsigned B = 31 - i;
    if (i == 0) begin : g_first
      assign sq_v_in[i]   = m4_valid_q;
      assign sq_rem_in[i] = m4_x_q;
      assign sq_res_in[i] = '0;
      assign sq_mid_in[i] = m4_mid_q;
    end else begin : g_next
      assign sq_v_in[i]   = sq_valid_q[i-1];
      assign sq_rem_in[i] = sq_rem_q[i-1];
      assign sq_res_in[i] = sq_res_q[i-1];
      assign sq_mid_in[i] = sq_mid_q[i-1];
    end
    // (res + 2^b)^2 - res^2
    assign sq_trial[i] = (66'(sq_res_in[i]) << (B + 1)) + (66'd1 << (2 * B));
    assign sq_take[i]  = {2'b00, sq_rem_in[i]} >= sq_trial[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQ_N; i++) sq_valid_q[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < SQ_N; i++) sq_valid_q[i] <= sq_v_in[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < SQ_N; i++) begin
        sq_rem_q[i] <= sq_take[i] ? sq_rem_in[i] - sq_trial[i][63:0] : sq_rem_in[i];
        sq_res_q[i] <= sq_take[i] ? (sq_res_in[i] | (32'd1 << (31 - i))) : sq_res_in[i];
        sq_mid_q[i] <= sq_mid_in[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // quantile from the root, saturation, status mask
  // --------------------------------------------------------------------------
  tq_pkg::mid_t       z_mid;
  logic signed [33:0] z_root;
  logic signed [33:0] z_val;
  logic signed [64:0] z_ext;
  logic signed [31:0] z_quantile;

  assign z_mid  = sq_mid_q[SQ_N-1];
  assign z_root = $signed({2'b00, sq_res_q[SQ_N-1]});
  assign z_val  = z_mid.rising ? 34'(z_mid.lo) + z_root : 34'(z_mid.hi) - z_root;
  assign z_ext  = 65'(z_val);

  always_comb begin
    priority if (z_mid.status != tq_pkg::ST_OK) begin
      z_quantile = '0;
    end else if (z_ext > SAT_HI) begin
      z_quantile = SAT_HI[31:0];
    end else if (z_ext < SAT_LO) begin
      z_quantile = SAT_LO[31:0];
    end else begin
      z_quantile = z_ext[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // output register with one skid entry
  // --------------------------------------------------------------------------
  logic               out_valid_q, out_valid_d, skid_valid_d;
  logic               out_take, load_last, load_skid, skid_load;
  logic signed [31:0] out_quantile_q, skid_quantile_q;
  tq_pkg::status_e    out_status_q, skid_status_q;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_take;
    skid_valid_d = skid_valid_q;
    load_last    = 1'b0;
    load_skid    = 1'b0;
    skid_load    = 1'b0;
    priority if (skid_valid_q) begin
      if (out_take) begin
        load_skid    = 1'b1;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (sq_valid_q[SQ_N-1]) begin
      if (!out_valid_q || out_take) begin
        load_last   = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else begin
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_last) begin
      out_quantile_q <= z_quantile;
      out_status_q   <= z_mid.status;
    end else if (load_skid) begin
      out_quantile_q <= skid_quantile_q;
      out_status_q   <= skid_status_q;
    end
    if (skid_load) begin
      skid_quantile_q <= z_quantile;
      skid_status_q   <= z_mid.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quantile_o  = out_quantile_q;
  assign status_o    = out_status_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // skid only holds an item behind a waiting output
  `TQ_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // a failed item never carries a value
  `TQ_ASSERT_IMP(a_bad_status_zero, clk_i, rst_ni, out_valid_q && (out_status_q != tq_pkg::ST_OK), out_quantile_q == 32'sd0)
  // skid fills only when the output was stalled
  `TQ_ASSERT_NXT(a_skid_fill_cause, clk_i, rst_ni, !skid_valid_q && !(out_valid_q && out_stall_i), !skid_valid_q)

endmodule
